@@ hdl/isml_pkg.sv @@
// Shared types and constants of the merged interval set lookup block.
`default_nettype none

package isml_pkg;

    localparam int MAX_RANGES  = 256;
    localparam int VALUE_WIDTH = 48;

    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int IN_DATA_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 + CNT_W + 7) / 8) * 8;

    typedef logic [VALUE_WIDTH-1:0] t_val;
    typedef logic [CNT_W-1:0]       t_cnt;

    // Operation broadcast to every cell of the row
    typedef enum logic [1:0] {
        OP_IDLE = 2'd0,
        OP_CMP  = 2'd1,
        OP_INS  = 2'd2,
        OP_FOLD = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     merge;   // new range folds into the entry just below it
        logic     absorb;  // new range swallows the entry at its slot
    } t_cell_cmd;

    // What a cell shows to its two neighbors
    typedef struct packed {
        t_val lo;
        t_val hi;
        logic vld;
        logic a;   // lo <= probe, prefix of the table
        logic f;   // stored range starts inside the new range: s < lo <= e
    } t_cell_link;

    typedef struct packed {
        logic hit;
        logic mcand;
        logic fold;
    } t_cell_flags;

    typedef struct packed {
        logic hit;
        logic merge;
        logic absorb;
        logic fold;
    } t_chain_stat;

    localparam t_cell_link LINK_LEFT_END = '{lo: '0, hi: '0, vld: 1'b0, a: 1'b1, f: 1'b0};
    localparam t_cell_link LINK_RIGHT_END = '{lo: '0, hi: '0, vld: 1'b0, a: 1'b0, f: 1'b0};

endpackage

`default_nettype wire

@@ hdl/isml_cell.sv @@
// One table slot: holds a range, compares it and trades data with its neighbors.
`default_nettype none

module isml_cell
    import isml_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cell_cmd   i_cmd,
    input  t_val        i_s,
    input  t_val        i_e,
    input  t_cell_link  i_left,
    input  t_cell_link  i_right,
    output t_cell_link  o_link,
    output t_cell_flags o_flags
);

    t_val r_lo, n_lo;
    t_val r_hi, n_hi;
    logic r_vld, n_vld;
    logic r_a, n_a;
    logic r_f, n_f;
    logic r_h, n_h;
    logic r_g, n_g;
    logic r_tgt, n_tgt;
    logic r_aft, n_aft;

    logic w_last_a;
    logic w_first_na;
    t_val w_hi_e;

    assign w_last_a   = r_a & ~i_right.a;
    assign w_first_na = ~r_a & i_left.a;
    assign w_hi_e     = r_g ? i_e : r_hi;

    always_comb begin
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_vld = r_vld;
        n_a   = r_a;
        n_f   = r_f;
        n_h   = r_h;
        n_g   = r_g;
        n_tgt = r_tgt;
        n_aft = r_aft;
        case (i_cmd.op)
            OP_CMP: begin
                n_a = r_vld && (r_lo <= i_s);
                n_f = r_vld && (r_lo > i_s) && (r_lo <= i_e);
                n_h = (i_s <= r_hi);
                n_g = (i_e > r_hi);
            end
            OP_INS: begin
                if (i_cmd.merge) begin
                    // slot below the new range widens, everything above it is tail
                    n_tgt = w_last_a;
                    n_aft = ~r_a;
                    if (w_last_a) begin
                        n_hi = w_hi_e;
                    end
                end else begin
                    n_tgt = w_first_na;
                    n_aft = ~r_a & ~w_first_na;
                    if (i_cmd.absorb) begin
                        if (w_first_na) begin
                            n_lo = i_s;
                            n_hi = w_hi_e;
                            n_f  = 1'b0;
                        end
                    end else if (w_first_na) begin
                        n_lo  = i_s;
                        n_hi  = i_e;
                        n_vld = 1'b1;
                        n_f   = 1'b0;
                    end else if (!r_a) begin
                        // open a slot: tail moves up by one
                        n_lo  = i_left.lo;
                        n_hi  = i_left.hi;
                        n_vld = i_left.vld;
                        n_f   = i_left.f;
                    end
                end
            end
            OP_FOLD: begin
                if (r_tgt) begin
                    if (i_right.hi > r_hi) begin
                        n_hi = i_right.hi;
                    end
                end else if (r_aft) begin
                    n_lo  = i_right.lo;
                    n_hi  = i_right.hi;
                    n_vld = i_right.vld;
                    n_f   = i_right.f;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_a   <= 1'b0;
            r_f   <= 1'b0;
            r_h   <= 1'b0;
            r_g   <= 1'b0;
            r_tgt <= 1'b0;
            r_aft <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_a   <= n_a;
            r_f   <= n_f;
            r_h   <= n_h;
            r_g   <= n_g;
            r_tgt <= n_tgt;
            r_aft <= n_aft;
        end
    end

    assign o_link.lo  = r_lo;
    assign o_link.hi  = r_hi;
    assign o_link.vld = r_vld;
    assign o_link.a   = r_a;
    assign o_link.f   = r_f;

    assign o_flags.hit   = r_a & r_h;
    assign o_flags.mcand = w_last_a & r_h;
    assign o_flags.fold  = r_aft & r_f;

endmodule

`default_nettype wire

@@ hdl/isml_chain.sv @@
// Row of table cells with neighbor links and the status reductions.
`default_nettype none

module isml_chain
    import isml_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cell_cmd   i_cmd,
    input  t_val        i_s,
    input  t_val        i_e,
    output t_chain_stat o_stat
);

    t_cell_link  w_link  [MAX_RANGES];
    t_cell_link  w_left  [MAX_RANGES];
    t_cell_link  w_right [MAX_RANGES];
    t_cell_flags w_flags [MAX_RANGES];

    logic [MAX_RANGES-1:0] w_hit;
    logic [MAX_RANGES-1:0] w_mcand;
    logic [MAX_RANGES-1:0] w_fold;
    logic [MAX_RANGES-1:0] w_f;

    for (genvar gi = 0; gi < MAX_RANGES; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_left[gi] = LINK_LEFT_END;
        end else begin : g_mid_l
            assign w_left[gi] = w_link[gi-1];
        end
        if (gi == MAX_RANGES - 1) begin : g_last
            assign w_right[gi] = LINK_RIGHT_END;
        end else begin : g_mid_r
            assign w_right[gi] = w_link[gi+1];
        end

        isml_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_s     (i_s),
            .i_e     (i_e),
            .i_left  (w_left[gi]),
            .i_right (w_right[gi]),
            .o_link  (w_link[gi]),
            .o_flags (w_flags[gi])
        );

        assign w_hit[gi]   = w_flags[gi].hit;
        assign w_mcand[gi] = w_flags[gi].mcand;
        assign w_fold[gi]  = w_flags[gi].fold;
        assign w_f[gi]     = w_link[gi].f;
    end

    // single-bit reductions over registered per-cell flags
    assign o_stat.hit    = |w_hit;
    assign o_stat.merge  = |w_mcand;
    assign o_stat.absorb = |w_f;
    assign o_stat.fold   = |w_fold;

endmodule

`default_nettype wire

@@ hdl/isml_ctrl.sv @@
// Sequencer: request intake, per-step commands to the row, range count and result register.
`default_nettype none

module isml_ctrl
    import isml_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  [IN_DATA_W-1:0]  i_in_data,
    input  wire                   i_in_query,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data,
    input  t_chain_stat           i_stat,
    output t_cell_cmd             o_cmd,
    output t_val                  o_s,
    output t_val                  o_e
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CMP  = 5'b00010,
        ST_INS  = 5'b00100,
        ST_MRG  = 5'b01000,
        ST_RES  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    logic   r_act;
    t_val   r_s;
    t_val   r_e;
    logic   r_full;
    logic   r_out_vld;
    logic   r_out_found;
    logic   r_out_full;
    t_cnt   r_out_cnt;

    logic   w_accept;
    logic   w_drop;
    logic   w_load;
    logic   w_table_full;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_table_full = (r_cnt == CNT_W'(MAX_RANGES)) && !i_stat.merge && !i_stat.absorb;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd.op     = OP_IDLE;
        o_cmd.merge  = i_stat.merge;
        o_cmd.absorb = i_stat.absorb;
        w_drop       = 1'b0;
        w_load       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = r_act ? ST_RES : ST_INS;
            end
            ST_INS: begin
                if (w_table_full) begin
                    w_drop  = 1'b1;
                    n_state = ST_RES;
                end else begin
                    o_cmd.op = OP_INS;
                    if (!i_stat.merge && !i_stat.absorb) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    n_state = ST_MRG;
                end
            end
            ST_MRG: begin
                // one swallowed range leaves the table per cycle
                if (i_stat.fold) begin
                    o_cmd.op = OP_FOLD;
                    n_cnt    = r_cnt - CNT_W'(1);
                end else begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (!r_out_vld || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_in_query;
            r_s   <= i_in_data[VALUE_WIDTH-1:0];
            r_e   <= i_in_data[2*VALUE_WIDTH-1:VALUE_WIDTH];
        end
        if (w_load) begin
            r_out_found <= r_act & i_stat.hit;
            r_out_full  <= r_full;
            r_out_cnt   <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_full    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_accept) begin
                r_full <= 1'b0;
            end else if (w_drop) begin
                r_full <= 1'b1;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_s         = r_s;
    assign o_e         = r_e;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = {{(OUT_DATA_W - 2 - CNT_W){1'b0}}, r_out_cnt, r_out_full, r_out_found};

endmodule

`default_nettype wire

@@ hdl/interval_set_merge_lookup_top.sv @@
// Top level of the merged interval set lookup block.
//
// Keeps up to MAX_RANGES sorted, disjoint inclusive ranges in a row of cells.
// Slave stream: s_axis_tuser = 0 inserts [first, last], 1 queries first.
// Every request gives exactly one result on the master stream: found,
// table_full (insert dropped, table unchanged) and the range count after it.
// Steps: a query goes through compare and result. An insert goes through
// compare, insert, the fold loop and result; the fold loop moves the tail
// of the row down by one cell per cycle while a swallowed range remains.
// An insert dropped on a full table goes through compare, the insert step
// (where it is dropped) and result. A new request is taken only in idle,
// once the last one has reached its result step and been loaded.
// The output register holds a result while the receiver stalls; the next
// request is still taken and waits in its last step until the register frees.
// Synchronous reset empties the table by clearing every cell's valid flag, with no clearing pass.
`default_nettype none

module interval_set_merge_lookup_top
    import isml_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,   // first_value, last_value
    input  wire                   s_axis_tuser,   // action
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // found, table_full, range_count, zero pad
);

    t_cell_cmd   w_cmd;
    t_chain_stat w_stat;
    t_val        w_s;
    t_val        w_e;

    isml_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_query  (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_s         (w_s),
        .o_e         (w_e)
    );

    isml_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_s     (w_s),
        .i_e     (w_e),
        .o_stat  (w_stat)
    );

endmodule

`default_nettype wire
